### hdl/cse_pkg.sv
// Shared types and constants of the cosine similarity engine.
package cse_pkg;

   localparam int ELEM_BITS  = 16;
   localparam int PROD_BITS  = 2 * ELEM_BITS;
   localparam int ACC_BITS   = 41;
   localparam int ROOT_BITS  = (ACC_BITS + 1) / 2;
   localparam int RAD_BITS   = 2 * ROOT_BITS;
   localparam int REM_BITS   = ROOT_BITS + 2;
   localparam int DEN_BITS   = 2 * ROOT_BITS;
   localparam int FRAC_BITS  = 15;
   localparam int QUO_BITS   = FRAC_BITS + 2;
   localparam int ROOT_STEPS = ROOT_BITS;
   localparam int DIV_STEPS  = QUO_BITS;
   localparam int CNT_BITS   = $clog2(ROOT_STEPS);

   localparam logic signed [ELEM_BITS-1:0] SIM_MAX = {1'b0, {(ELEM_BITS-1){1'b1}}};
   localparam logic signed [ELEM_BITS-1:0] SIM_MIN = {1'b1, {(ELEM_BITS-1){1'b0}}};
   localparam logic [QUO_BITS-1:0] NEG_LIMIT = QUO_BITS'(1) << FRAC_BITS;

   typedef enum logic [2:0] {
      ST_ACCUM,
      ST_DRAIN,
      ST_LOAD,
      ST_ROOT,
      ST_MULT,
      ST_DIV_INIT,
      ST_DIV,
      ST_FINISH
   } cse_state_type;

   typedef struct packed {
      logic take;
      logic load;
      logic root_step;
      logic mult;
      logic div_init;
      logic div_step;
      logic out_load;
   } cse_cmd_type;

endpackage

### hdl/cse_channels.sv
// Valid/ready channel interfaces for the element pairs and the results.
interface cse_req_if;
   logic                                   valid;
   logic                                   ready;
   logic signed [cse_pkg::ELEM_BITS-1:0]   a_value;
   logic signed [cse_pkg::ELEM_BITS-1:0]   b_value;
   logic                                   a_present;
   logic                                   b_present;
   logic                                   last;

   modport source (output valid, a_value, b_value, a_present, b_present, last,
                   input ready);
   modport sink (input valid, a_value, b_value, a_present, b_present, last,
                 output ready);
endinterface

interface cse_rsp_if;
   logic                                   valid;
   logic                                   ready;
   logic signed [cse_pkg::ELEM_BITS-1:0]   similarity_out;
   logic                                   zero_norm;

   modport source (output valid, similarity_out, zero_norm, input ready);
   modport sink (input valid, similarity_out, zero_norm, output ready);
endinterface

### hdl/cse_sqrt.sv
// Bit-serial floor square root, two radicand bits per step.
module cse_sqrt (
   input  logic                          clock,
   input  logic                          load,
   input  logic                          step,
   input  logic [cse_pkg::ACC_BITS-1:0]  value,
   output logic [cse_pkg::ROOT_BITS-1:0] root
);
   import cse_pkg::*;

   logic [RAD_BITS-1:0]  rad_ff, rad_in;
   logic [REM_BITS-1:0]  rem_ff, rem_in;
   logic [ROOT_BITS-1:0] root_ff, root_in;
   logic [REM_BITS+1:0]  cat;
   logic [REM_BITS+1:0]  trial;

   always_comb begin
      cat     = {rem_ff, rad_ff[RAD_BITS-1 -: 2]};
      trial   = {2'b00, root_ff, 2'b01};
      rad_in  = rad_ff;
      rem_in  = rem_ff;
      root_in = root_ff;
      if (load) begin
         rad_in  = RAD_BITS'(value);
         rem_in  = '0;
         root_in = '0;
      end else if (step) begin
         rad_in = rad_ff << 2;
         // The remainder never exceeds twice the partial root, so it fits.
         if (cat >= trial) begin
            rem_in  = REM_BITS'(cat - trial);
            root_in = {root_ff[ROOT_BITS-2:0], 1'b1};
         end else begin
            rem_in  = cat[REM_BITS-1:0];
            root_in = {root_ff[ROOT_BITS-2:0], 1'b0};
         end
      end
   end

   always_ff @(posedge clock) begin
      rad_ff  <= rad_in;
      rem_ff  <= rem_in;
      root_ff <= root_in;
   end

   assign root = root_ff;

endmodule

### hdl/cse_datapath.sv
// Accumulators, square roots, denominator product, divider and result register.
module cse_datapath (
   input  logic                                 clock,
   input  logic                                 reset,
   input  cse_pkg::cse_cmd_type                 cmd,
   input  logic signed [cse_pkg::ELEM_BITS-1:0] a_value,
   input  logic signed [cse_pkg::ELEM_BITS-1:0] b_value,
   input  logic                                 a_present,
   input  logic                                 b_present,
   output logic signed [cse_pkg::ELEM_BITS-1:0] similarity_out,
   output logic                                 zero_norm
);
   import cse_pkg::*;

   // Product stage.
   logic                        pvalid_ff;
   logic                        pa_ff, pb_ff;
   logic signed [PROD_BITS-1:0] pdot_ff;
   logic [PROD_BITS-2:0]        psqa_ff, psqb_ff;
   logic signed [PROD_BITS-1:0] mul_ab, mul_aa, mul_bb;

   // Accumulators.
   logic signed [ACC_BITS-1:0] dot_ff, dot_in;
   logic [ACC_BITS-1:0]        sqa_ff, sqa_in, sqb_ff, sqb_in;
   logic signed [ACC_BITS:0]   dot_sum;
   logic [ACC_BITS:0]          sqa_sum, sqb_sum;

   // Finishing arithmetic.
   logic [ROOT_BITS-1:0] root_a, root_b;
   logic                 neg_ff;
   logic [ACC_BITS-1:0]  mag_ff;
   logic [DEN_BITS-1:0]  den_ff;
   logic                 zero_ff, sat_ff;
   logic [DEN_BITS-1:0]  rem_ff, rem_in;
   logic [QUO_BITS-1:0]  low_ff, quo_ff;
   logic [DEN_BITS:0]    shifted;
   logic                 qbit;
   logic signed [ELEM_BITS-1:0] sim;
   logic signed [ELEM_BITS-1:0] sim_ff;
   logic                        zero_norm_ff;

   assign mul_ab = a_value * b_value;
   assign mul_aa = a_value * a_value;
   assign mul_bb = b_value * b_value;

   always_ff @(posedge clock) begin
      if (reset) begin
         pvalid_ff <= 1'b0;
      end else begin
         pvalid_ff <= cmd.take;
      end
      if (cmd.take) begin
         pa_ff   <= a_present;
         pb_ff   <= b_present;
         pdot_ff <= mul_ab;
         psqa_ff <= mul_aa[PROD_BITS-2:0];
         psqb_ff <= mul_bb[PROD_BITS-2:0];
      end
   end

   always_comb begin
      dot_sum = {dot_ff[ACC_BITS-1], dot_ff} + (ACC_BITS+1)'(pdot_ff);
      sqa_sum = {1'b0, sqa_ff} + (ACC_BITS+1)'(psqa_ff);
      sqb_sum = {1'b0, sqb_ff} + (ACC_BITS+1)'(psqb_ff);
      dot_in  = dot_ff;
      sqa_in  = sqa_ff;
      sqb_in  = sqb_ff;
      if (cmd.load) begin
         dot_in = '0;
         sqa_in = '0;
         sqb_in = '0;
      end else if (pvalid_ff) begin
         if (pa_ff) begin
            sqa_in = sqa_sum[ACC_BITS] ? '1 : sqa_sum[ACC_BITS-1:0];
         end
         if (pb_ff) begin
            sqb_in = sqb_sum[ACC_BITS] ? '1 : sqb_sum[ACC_BITS-1:0];
         end
         if (pa_ff && pb_ff) begin
            // The top two bits disagree only when the sum left the signed range.
            unique case (dot_sum[ACC_BITS:ACC_BITS-1])
               2'b01:   dot_in = {1'b0, {(ACC_BITS-1){1'b1}}};
               2'b10:   dot_in = {1'b1, {(ACC_BITS-1){1'b0}}};
               default: dot_in = dot_sum[ACC_BITS-1:0];
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         dot_ff <= '0;
         sqa_ff <= '0;
         sqb_ff <= '0;
      end else begin
         dot_ff <= dot_in;
         sqa_ff <= sqa_in;
         sqb_ff <= sqb_in;
      end
   end

   cse_sqrt u_sqrt_a (
      .clock (clock),
      .load  (cmd.load),
      .step  (cmd.root_step),
      .value (sqa_ff),
      .root  (root_a)
   );

   cse_sqrt u_sqrt_b (
      .clock (clock),
      .load  (cmd.load),
      .step  (cmd.root_step),
      .value (sqb_ff),
      .root  (root_b)
   );

   always_comb begin
      shifted = {rem_ff, low_ff[QUO_BITS-1]};
      qbit    = shifted >= {1'b0, den_ff};
      rem_in  = qbit ? DEN_BITS'(shifted - {1'b0, den_ff}) : shifted[DEN_BITS-1:0];
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         neg_ff <= dot_ff[ACC_BITS-1];
         mag_ff <= dot_ff[ACC_BITS-1] ? ACC_BITS'(-dot_ff) : ACC_BITS'(dot_ff);
      end
      if (cmd.mult) begin
         den_ff <= root_a * root_b;
      end
      if (cmd.div_init) begin
         zero_ff <= (den_ff == '0);
         // A quotient of four or more in integer terms cannot fit the result.
         sat_ff  <= {3'b000, mag_ff} >= {den_ff, 2'b00};
         rem_ff  <= DEN_BITS'(mag_ff >> 2);
         low_ff  <= {mag_ff[1:0], {FRAC_BITS{1'b0}}};
         quo_ff  <= '0;
      end else if (cmd.div_step) begin
         rem_ff <= rem_in;
         low_ff <= low_ff << 1;
         quo_ff <= {quo_ff[QUO_BITS-2:0], qbit};
      end
   end

   always_comb begin
      if (zero_ff) begin
         sim = '0;
      end else if (neg_ff) begin
         sim = (sat_ff || quo_ff > NEG_LIMIT) ? SIM_MIN : ELEM_BITS'(-quo_ff);
      end else begin
         sim = (sat_ff || quo_ff[QUO_BITS-1:FRAC_BITS] != '0) ? SIM_MAX
                                                              : ELEM_BITS'(quo_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.out_load) begin
         sim_ff       <= sim;
         zero_norm_ff <= zero_ff;
      end
   end

   assign similarity_out = sim_ff;
   assign zero_norm      = zero_norm_ff;

endmodule

### hdl/cse_ctrl.sv
// Sequencer that steps the datapath through accumulation, roots and division.
module cse_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   input  logic                 req_last,
   input  logic                 rsp_ready,
   output logic                 req_ready,
   output logic                 rsp_valid,
   output cse_pkg::cse_cmd_type cmd
);
   import cse_pkg::*;

   cse_state_type       state_ff, state_in;
   logic [CNT_BITS-1:0] cnt_ff, cnt_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic                req_accept;
   logic                out_free;

   assign req_accept = req_valid && req_ready;
   assign out_free   = !rsp_valid_ff || rsp_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_ACCUM;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      cnt_in    = cnt_ff;
      cmd       = '0;
      req_ready = 1'b0;
      unique case (state_ff)
         ST_ACCUM: begin
            req_ready = 1'b1;
            cmd.take  = req_valid;
            if (req_valid && req_last) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            state_in = ST_LOAD;
         end
         ST_LOAD: begin
            cmd.load = 1'b1;
            cnt_in   = '0;
            state_in = ST_ROOT;
         end
         ST_ROOT: begin
            cmd.root_step = 1'b1;
            if (cnt_ff == CNT_BITS'(ROOT_STEPS - 1)) begin
               cnt_in   = '0;
               state_in = ST_MULT;
            end else begin
               cnt_in = cnt_ff + 1'b1;
            end
         end
         ST_MULT: begin
            cmd.mult = 1'b1;
            state_in = ST_DIV_INIT;
         end
         ST_DIV_INIT: begin
            cmd.div_init = 1'b1;
            state_in     = ST_DIV;
         end
         ST_DIV: begin
            cmd.div_step = 1'b1;
            if (cnt_ff == CNT_BITS'(DIV_STEPS - 1)) begin
               cnt_in   = '0;
               state_in = ST_FINISH;
            end else begin
               cnt_in = cnt_ff + 1'b1;
            end
         end
         ST_FINISH: begin
            if (out_free) begin
               cmd.out_load = 1'b1;
               state_in     = ST_ACCUM;
            end
         end
         default: begin
            state_in = ST_ACCUM;
         end
      endcase
      rsp_valid_in = cmd.out_load || (rsp_valid_ff && !rsp_ready);
   end

   assign rsp_valid = rsp_valid_ff;

`ifndef SYNTHESIS
   a_load_free: assert property (@(posedge clock) disable iff (reset)
      cmd.out_load |-> out_free)
      else $error("result loaded over an item still waiting");

   a_load_shows: assert property (@(posedge clock) disable iff (reset)
      cmd.out_load |=> rsp_valid_ff)
      else $error("loaded result not presented");

   a_last_drains: assert property (@(posedge clock) disable iff (reset)
      (req_accept && req_last) |=> (state_ff == ST_DRAIN))
      else $error("last pair did not start the finishing sequence");

   a_cnt_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DIV) |-> (cnt_ff < CNT_BITS'(DIV_STEPS)))
      else $error("divider step count out of range");
`endif

endmodule

### hdl/cosine_similarity_engine.sv
// Top level of the streaming cosine similarity engine.
//
// Element pairs arrive on req_if, one item per cycle while a vector streams in.
// Each item carries a_value and b_value (signed Q1.15), presence flags for the
// two vectors, and last on the final position. The dot product sums only
// positions where both vectors are present; each sum of squares covers its own
// vector, and all sums saturate instead of wrapping.
// After the item with last is accepted, req_if.ready stays low while the block
// finishes: a drain state, a load state, the steps of the bit-serial square
// roots, a multiply state, a divider setup state, the divider steps and a state
// that loads the output register once it is free; the result item then appears
// on rsp_if. The root and divide sequence sets the overhead per vector.
// The result sits in an output register until rsp_if.ready takes it; the next
// vector streams in meanwhile, and a stalled receiver holds the block only when
// the next result is ready to be written.
// Synchronous reset clears the accumulators and the sequencer and drops
// rsp_if.valid.
module cosine_similarity_engine (
   input  logic        clock,
   input  logic        reset,
   cse_req_if.sink     req_if,
   cse_rsp_if.source   rsp_if
);
   import cse_pkg::*;

   cse_cmd_type cmd;

   cse_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_if.valid),
      .req_last  (req_if.last),
      .rsp_ready (rsp_if.ready),
      .req_ready (req_if.ready),
      .rsp_valid (rsp_if.valid),
      .cmd       (cmd)
   );

   cse_datapath u_datapath (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .a_value        (req_if.a_value),
      .b_value        (req_if.b_value),
      .a_present      (req_if.a_present),
      .b_present      (req_if.b_present),
      .similarity_out (rsp_if.similarity_out),
      .zero_norm      (rsp_if.zero_norm)
   );

endmodule

### tb/tb_cosine_similarity_engine.sv
`timescale 1ns / 100ps
// Self-checking testbench for the cosine similarity engine, with its own predictor.
module tb_cosine_similarity_engine;
   import cse_pkg::*;

   localparam int RANDOM_PAIRS = 400;
   localparam int CYCLE_LIMIT  = 500000;
   localparam int MAX_REPORTS  = 10;
   localparam int TAIL_PAIRS   = 250;
   localparam int HOLD_CYCLES  = 400;
   localparam int HOLD_AFTER   = 12;
   localparam int DRAIN_CYCLES = 60;

   localparam longint unsigned SQUARE_LIMIT = (64'd1 << ACC_BITS) - 64'd1;
   localparam longint signed   DOT_HIGH     = (64'sd1 << (ACC_BITS - 1)) - 64'sd1;
   localparam longint signed   DOT_LOW      = -DOT_HIGH - 64'sd1;
   localparam longint unsigned POS_MAG      = (64'd1 << FRAC_BITS) - 64'd1;
   localparam longint unsigned NEG_MAG      = 64'd1 << FRAC_BITS;

   typedef struct {
      logic signed [ELEM_BITS-1:0] a_value;
      logic signed [ELEM_BITS-1:0] b_value;
      logic                        a_present;
      logic                        b_present;
      logic                        last;
   } pair_type;

   typedef struct {
      logic signed [ELEM_BITS-1:0] similarity;
      logic                        zero_norm;
   } similarity_type;

   typedef enum int {
      FILL_RANDOM,
      FILL_SPARSE,
      FILL_MATCHED,
      FILL_OPPOSED,
      FILL_EXTREME,
      FILL_EMPTY
   } fill_type;

   logic clock;
   logic reset;

   cse_req_if req_if ();
   cse_rsp_if rsp_if ();

   cosine_similarity_engine dut (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_if),
      .rsp_if (rsp_if)
   );

   // Predictor state.
   longint signed   dot_acc = 0;
   longint unsigned square_acc_a = 0;
   longint unsigned square_acc_b = 0;

   pair_type       pair_queue[$];
   similarity_type similarity_queue[$];
   similarity_type next_result;

   int error_count    = 0;
   int results_seen   = 0;
   int pairs_accepted = 0;
   int cycle_count    = 0;
   int gap_left       = 0;
   int stall_left     = 0;
   int hold_left      = 0;
   bit offered        = 0;
   bit hold_done      = 0;

   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   function automatic longint unsigned floor_root(longint unsigned radicand);
      longint unsigned root;
      longint unsigned probe;
      root  = 0;
      probe = 64'd1 << 62;
      while (probe > radicand)
         probe >>= 2;
      while (probe != 0) begin
         if (radicand >= root + probe) begin
            radicand -= root + probe;
            root = (root >> 1) + probe;
         end else begin
            root >>= 1;
         end
         probe >>= 2;
      end
      return root;
   endfunction

   function automatic longint unsigned add_square(longint unsigned acc,
                                                  logic signed [ELEM_BITS-1:0] value);
      longint signed   wide;
      longint unsigned sum;
      wide = 64'(value);
      sum  = acc + $unsigned(wide * wide);
      return (sum > SQUARE_LIMIT) ? SQUARE_LIMIT : sum;
   endfunction

   // Folds one accepted item into the sums and, on last, queues the expected result.
   function automatic void accumulate_pair(pair_type pair);
      longint signed   a;
      longint signed   b;
      longint signed   dot;
      longint unsigned magnitude;
      longint unsigned quotient;
      longint unsigned denom;
      similarity_type  result;
      a = 64'(pair.a_value);
      b = 64'(pair.b_value);
      if (pair.a_present)
         square_acc_a = add_square(square_acc_a, pair.a_value);
      if (pair.b_present)
         square_acc_b = add_square(square_acc_b, pair.b_value);
      if (pair.a_present && pair.b_present) begin
         dot = dot_acc + a * b;
         if (dot > DOT_HIGH)
            dot = DOT_HIGH;
         if (dot < DOT_LOW)
            dot = DOT_LOW;
         dot_acc = dot;
      end
      if (!pair.last)
         return;
      denom = floor_root(square_acc_a) * floor_root(square_acc_b);
      result.similarity = '0;
      result.zero_norm  = (denom == 0);
      if (denom != 0) begin
         magnitude = (dot_acc < 0) ? $unsigned(-dot_acc) : $unsigned(dot_acc);
         quotient  = (magnitude << FRAC_BITS) / denom;
         if (dot_acc < 0)
            result.similarity = (quotient > NEG_MAG) ? SIM_MIN : ELEM_BITS'(64'd0 - quotient);
         else
            result.similarity = (quotient > POS_MAG) ? SIM_MAX : ELEM_BITS'(quotient);
      end
      similarity_queue = {similarity_queue, result};
      dot_acc      = 0;
      square_acc_a = 0;
      square_acc_b = 0;
   endfunction

   function automatic void queue_pair(int a, int b, bit a_present, bit b_present, bit last);
      pair_type pair;
      pair.a_value   = ELEM_BITS'(a);
      pair.b_value   = ELEM_BITS'(b);
      pair.a_present = a_present;
      pair.b_present = b_present;
      pair.last      = last;
      pair_queue = {pair_queue, pair};
   endfunction

   function automatic int pick_value(fill_type fill);
      if (fill == FILL_EXTREME) begin
         case ($urandom_range(0, 5))
            0:       return -32768;
            1:       return 32767;
            2:       return -1;
            3:       return 0;
            4:       return 1;
            default: return int'($urandom_range(0, 65535)) - 32768;
         endcase
      end
      return int'($urandom_range(0, 65535)) - 32768;
   endfunction

   function automatic void add_vector(fill_type fill, int length);
      int a;
      int b;
      bit a_present;
      bit b_present;
      for (int i = 0; i < length; i++) begin
         a = pick_value(fill);
         b = pick_value(fill);
         a_present = 1'b1;
         b_present = 1'b1;
         case (fill)
            FILL_MATCHED: b = a;
            FILL_OPPOSED: b = -a;
            FILL_SPARSE: begin
               a_present = 1'($urandom_range(0, 1));
               b_present = 1'($urandom_range(0, 1));
            end
            FILL_EMPTY: begin
               a_present = 1'($urandom_range(0, 1));
               b_present = 1'b0;
            end
            default: begin
               // Occasional holes make the two vectors differ in length.
               if ($urandom_range(0, 24) == 0)
                  a_present = 1'b0;
               if ($urandom_range(0, 24) == 0)
                  b_present = 1'b0;
            end
         endcase
         queue_pair(a, b, a_present, b_present, i == length - 1);
      end
   endfunction

   task automatic report_mismatch(string what);
      error_count++;
      if (error_count <= MAX_REPORTS)
         $display("%s", what);
   endtask

   // Sender: presents the item at the head of the queue at the falling edge.
   always @(negedge clock) begin
      if (reset) begin
         req_if.valid <= 1'b0;
      end else if (!offered) begin
         if (gap_left > 0) begin
            gap_left--;
            req_if.valid <= 1'b0;
         end else if (pair_queue.size() > 0) begin
            req_if.a_value   <= pair_queue[0].a_value;
            req_if.b_value   <= pair_queue[0].b_value;
            req_if.a_present <= pair_queue[0].a_present;
            req_if.b_present <= pair_queue[0].b_present;
            req_if.last      <= pair_queue[0].last;
            req_if.valid     <= 1'b1;
            offered = 1'b1;
         end else begin
            req_if.valid <= 1'b0;
         end
      end
   end

   always @(posedge clock) begin
      if (!reset && req_if.valid && req_if.ready) begin
         accumulate_pair(pair_queue.pop_front());
         offered = 1'b0;
         pairs_accepted++;
         if (pair_queue.size() > TAIL_PAIRS && (pairs_accepted / 300) % 4 != 3 &&
             $urandom_range(0, 15) == 0)
            gap_left = $urandom_range(1, 18);
      end
   end

   // Receiver: random stalls, plus one long hold-off that backs the block up.
   always @(negedge clock) begin
      if (reset) begin
         rsp_if.ready <= 1'b0;
      end else if (hold_left > 0) begin
         hold_left--;
         rsp_if.ready <= 1'b0;
      end else if (stall_left > 0) begin
         stall_left--;
         rsp_if.ready <= 1'b0;
      end else begin
         rsp_if.ready <= 1'b1;
         if (pair_queue.size() > TAIL_PAIRS && results_seen % 24 < 16 &&
             $urandom_range(0, 11) == 0)
            stall_left = $urandom_range(1, 18);
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_if.valid && rsp_if.ready) begin
         results_seen++;
         if (similarity_queue.size() == 0) begin
            report_mismatch($sformatf("result with nothing expected: similarity %0d zero_norm %0b",
                                      rsp_if.similarity_out, rsp_if.zero_norm));
         end else begin
            next_result = similarity_queue.pop_front();
            if (rsp_if.similarity_out !== next_result.similarity)
               report_mismatch($sformatf("result %0d similarity: expected %0d, got %0d",
                                         results_seen, next_result.similarity,
                                         rsp_if.similarity_out));
            if (rsp_if.zero_norm !== next_result.zero_norm)
               report_mismatch($sformatf("result %0d zero_norm: expected %0b, got %0b",
                                         results_seen, next_result.zero_norm,
                                         rsp_if.zero_norm));
         end
         if (results_seen == HOLD_AFTER && !hold_done) begin
            hold_left = HOLD_CYCLES;
            hold_done = 1'b1;
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("FAILURE");
         $finish;
      end
   end

   initial begin
      int       length;
      int       random_pairs;
      int       pick;
      fill_type fill;

      reset            = 1'b1;
      req_if.valid     = 1'b0;
      req_if.a_value   = '0;
      req_if.b_value   = '0;
      req_if.a_present = 1'b0;
      req_if.b_present = 1'b0;
      req_if.last      = 1'b0;
      rsp_if.ready     = 1'b0;

      // Directed vectors.
      // Last with nothing accumulated gives a zero denominator.
      queue_pair(0, 0, 1'b0, 1'b0, 1'b1);
      // Identical extreme pairs: the quotient lands on 32768 and saturates high.
      queue_pair(32767, 32767, 1'b1, 1'b1, 1'b1);
      queue_pair(-32768, -32768, 1'b1, 1'b1, 1'b1);
      // Opposite extremes: exactly -32768, the negative bound itself.
      queue_pair(-32768, 32767, 1'b1, 1'b1, 1'b1);
      queue_pair(1, -1, 1'b1, 1'b1, 1'b1);
      // A zero vector against a nonzero one.
      queue_pair(0, 5, 1'b1, 1'b1, 1'b1);
      // Orthogonal vectors.
      queue_pair(1000, 0, 1'b1, 1'b1, 1'b0);
      queue_pair(0, 1000, 1'b1, 1'b1, 1'b1);
      // Absent elements carry extreme values that must be ignored.
      queue_pair(12000, -7000, 1'b1, 1'b1, 1'b0);
      queue_pair(-32768, 32767, 1'b0, 1'b1, 1'b0);
      queue_pair(32767, -32768, 1'b1, 1'b0, 1'b0);
      queue_pair(-32768, -32768, 1'b0, 1'b0, 1'b1);
      // Unequal lengths: the first vector runs two positions longer.
      queue_pair(3000, 4000, 1'b1, 1'b1, 1'b0);
      queue_pair(-5000, 2000, 1'b1, 1'b1, 1'b0);
      queue_pair(8000, 0, 1'b1, 1'b0, 1'b0);
      queue_pair(-9000, 0, 1'b1, 1'b0, 1'b0);
      // Last position present in neither vector, after real elements.
      queue_pair(0, 0, 1'b0, 1'b0, 1'b1);
      // Only the second vector has elements.
      queue_pair(500, 600, 1'b0, 1'b1, 1'b1);

      // A vector longer than the nominal maximum: the dot product saturates negative.
      for (int i = 0; i < 1030; i++)
         queue_pair(-32768, 32767, 1'b1, 1'b1, i == 1029);

      random_pairs = 0;
      while (random_pairs < RANDOM_PAIRS) begin
         pick = $urandom_range(0, 19);
         if (pick < 16)
            length = $urandom_range(1, 12);
         else if (pick < 19)
            length = $urandom_range(13, 64);
         else
            length = $urandom_range(65, 200);
         pick = $urandom_range(0, 19);
         if (pick < 10)
            fill = FILL_RANDOM;
         else if (pick < 13)
            fill = FILL_SPARSE;
         else if (pick < 15)
            fill = FILL_MATCHED;
         else if (pick < 17)
            fill = FILL_OPPOSED;
         else if (pick < 19)
            fill = FILL_EXTREME;
         else
            fill = FILL_EMPTY;
         add_vector(fill, length);
         random_pairs += length;
      end

      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      while (pair_queue.size() != 0 || similarity_queue.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (error_count == 0)
         $display("SUCCESS");
      else
         $display("FAILURE");
      $finish;
   end

endmodule

### cosine_similarity_engine.f
hdl/cse_pkg.sv
hdl/cse_channels.sv
hdl/cse_sqrt.sv
hdl/cse_datapath.sv
hdl/cse_ctrl.sv
hdl/cosine_similarity_engine.sv
tb/tb_cosine_similarity_engine.sv
